@@ design/alx_pkg.sv @@
// Shared types and constants for the arithmetic expression lexer.
package alx_pkg;

	// Column and length counters saturate at min(2^COLUMN_BITS - 1, 65535).
	localparam int COLUMN_BITS = 16;
	localparam int CNT_W       = (COLUMN_BITS < 16) ? COLUMN_BITS : 16;
	localparam logic [CNT_W-1:0] CNT_LIMIT = {CNT_W{1'b1}};

	// Width of column and length fields on the result stream.
	localparam int TOK_W = 16;

	// Token queue geometry.
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

	// Token kinds.
	localparam logic [3:0] K_OPEN    = 4'd0;
	localparam logic [3:0] K_CLOSE   = 4'd1;
	localparam logic [3:0] K_FLOAT   = 4'd2;
	localparam logic [3:0] K_INT     = 4'd3;
	localparam logic [3:0] K_IDENT   = 4'd4;
	localparam logic [3:0] K_PLUS    = 4'd5;
	localparam logic [3:0] K_MINUS   = 4'd6;
	localparam logic [3:0] K_MUL     = 4'd7;
	localparam logic [3:0] K_DIV     = 4'd8;
	localparam logic [3:0] K_ARROW   = 4'd9;
	localparam logic [3:0] K_SEMI    = 4'd10;
	localparam logic [3:0] K_SPACE   = 4'd11;
	localparam logic [3:0] K_UNKNOWN = 4'd12;

	typedef struct packed {
		logic [3:0]       kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] len;
		logic             last;
	} tok_t;

	// Up to two tokens per input character; v1 is set only with v0.
	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} tok_pair_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} in_item_t;

endpackage

@@ design/alx_step.sv @@
// Lexer state registers and the per-character next-state and token logic.
module alx_step import alx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_item,
	output tok_pair_t toks
);

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_NUM   = 3'd1;
	localparam logic [2:0] MODE_IDENT = 3'd2;
	localparam logic [2:0] MODE_SPACE = 3'd3;
	localparam logic [2:0] MODE_MINUS = 3'd4;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_LIMIT) ? v : CNT_W'(v + 1'b1);
	endfunction

	logic [2:0]       mode_q, mode_n;
	logic [CNT_W-1:0] start_q, start_n;
	logic [CNT_W-1:0] len_q, len_n;
	logic [CNT_W-1:0] col_q, col_n;
	logic             dot_q, dot_n;

	logic is_digit, is_alpha, is_dot;
	logic pend_ok, extend, opened;
	tok_t pend, sng;
	logic sng_v;

	assign is_digit = (in_item.ch >= 8'h30) && (in_item.ch <= 8'h39);
	assign is_alpha = ((in_item.ch >= 8'h61) && (in_item.ch <= 8'h7A)) ||
	                  ((in_item.ch >= 8'h41) && (in_item.ch <= 8'h5A));
	assign is_dot   = (in_item.ch == CH_DOT);

	always_comb begin
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		col_n   = col_q;
		dot_n   = dot_q;
		toks    = '0;
		extend  = 1'b0;
		opened  = 1'b0;
		sng     = '0;
		sng_v   = 1'b0;

		// token for the open run, if any
		pend       = '0;
		pend.start = TOK_W'(start_q);
		pend.len   = TOK_W'(len_q);
		pend_ok    = 1'b1;
		case (mode_q)
			MODE_NUM:   pend.kind = dot_q ? K_FLOAT : K_INT;
			MODE_IDENT: pend.kind = K_IDENT;
			MODE_SPACE: pend.kind = K_SPACE;
			MODE_MINUS: begin
				pend.kind = K_MINUS;
				pend.len  = TOK_W'(1);
			end
			default:    pend_ok = 1'b0;
		endcase

		if (in_valid) begin
			if (in_item.eoi) begin
				toks.v0      = pend_ok;
				toks.t0      = pend;
				toks.t0.last = 1'b1;
				mode_n  = MODE_IDLE;
				len_n   = '0;
				dot_n   = 1'b0;
				start_n = '0;
				col_n   = '0;
			end else begin
				col_n = sat_inc(col_q);
				case (mode_q)
					MODE_NUM:   extend = is_digit || is_dot;
					MODE_IDENT: extend = is_alpha || (in_item.ch == CH_UNDER);
					MODE_SPACE: extend = (in_item.ch == CH_SPACE);
					default:    extend = 1'b0;
				endcase

				if ((mode_q == MODE_MINUS) && (in_item.ch == CH_GT)) begin
					// minus then '>' merges into one arrow token
					toks.v0   = 1'b1;
					toks.t0   = pend;
					toks.t0.kind = K_ARROW;
					toks.t0.len  = TOK_W'(2);
					toks.t0.last = 1'b1;
					mode_n = MODE_IDLE;
				end else if (extend) begin
					len_n = sat_inc(len_q);
					dot_n = dot_q | is_dot;
				end else begin
					mode_n = MODE_IDLE;
					len_n  = '0;
					dot_n  = 1'b0;
					opened = 1'b1;
					if (is_digit) begin
						mode_n = MODE_NUM;
					end else if (is_alpha) begin
						mode_n = MODE_IDENT;
					end else if (in_item.ch == CH_SPACE) begin
						mode_n = MODE_SPACE;
					end else if (in_item.ch == CH_DASH) begin
						mode_n = MODE_MINUS;
					end else begin
						opened    = 1'b0;
						sng_v     = 1'b1;
						sng.start = TOK_W'(col_q);
						sng.len   = TOK_W'(1);
						sng.last  = 1'b1;
						case (in_item.ch)
							CH_OPEN:  sng.kind = K_OPEN;
							CH_CLOSE: sng.kind = K_CLOSE;
							CH_PLUS:  sng.kind = K_PLUS;
							CH_STAR:  sng.kind = K_MUL;
							CH_SLASH: sng.kind = K_DIV;
							CH_SEMI:  sng.kind = K_SEMI;
							default:  sng.kind = K_UNKNOWN;
						endcase
					end
					if (opened) begin
						start_n = col_q;
						len_n   = CNT_W'(1);
					end
					if (pend_ok) begin
						toks.v0      = 1'b1;
						toks.t0      = pend;
						toks.t0.last = !sng_v;
						toks.v1      = sng_v;
						toks.t1      = sng;
					end else begin
						toks.v0 = sng_v;
						toks.t0 = sng;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			col_q   <= '0;
			dot_q   <= 1'b0;
		end else begin
			mode_q  <= mode_n;
			start_q <= start_n;
			len_q   <= len_n;
			col_q   <= col_n;
			dot_q   <= dot_n;
		end
	end

endmodule

@@ design/alx_tok_fifo.sv @@
// Token queue: takes up to two tokens per cycle, hands out one per cycle while pop is high.
module alx_tok_fifo import alx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_pair_t        push,
	input  logic             pop,
	output tok_t             head,
	output logic             head_valid,
	output logic [LVL_W-1:0] level
);

	tok_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [LVL_W-1:0] level_q;
	logic [1:0]       push_n;
	logic             do_pop;

	assign push_n     = {1'b0, push.v0} + {1'b0, push.v1};
	assign head_valid = (level_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem[rp_q];
	assign level      = level_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wp_q] <= push.t0;
		end
		if (push.v1) begin
			mem[PTR_W'(wp_q + 1'b1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= PTR_W'(wp_q + push_n);
			rp_q    <= PTR_W'(rp_q + do_pop);
			level_q <= LVL_W'(level_q + push_n - do_pop);
		end
	end

	// no overflow, even with a double push
	assert property (@(posedge clk) disable iff (!arst_n)
		(LVL_W + 1)'(level_q) + push_n <= (LVL_W + 1)'(FIFO_DEPTH) + do_pop)
		else $error("token queue overflow");

	// second slot only used together with the first
	assert property (@(posedge clk) disable iff (!arst_n) push.v1 |-> push.v0)
		else $error("second token pushed without first");

	// an untaken head stays put while new tokens land behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !pop) |=> (head_valid && $stable(head)))
		else $error("queue head changed while stalled");

endmodule

@@ design/arithmetic_expression_lexer_unit.sv @@
// Top level of the arithmetic expression lexer: input register, lexer, token queue.
//
//  channel  | dir | tdata (low bit up)                        | tuser        | tlast
//  s_axis   | in  | character[7:0]                            | end_of_input | -
//  m_axis   | out | token_kind[3:0] start_column[19:4]        | -            | last_of_run
//           |     | token_length[35:20] zero pad[39:36]       |              |
//
// One character transaction per cycle is taken while s_axis_tready is high. While a
// character sits in the input register, the lexer pushes zero, one or two tokens into
// an eight-entry queue, whose head drives m_axis. The m_axis side drains one token per
// cycle while m_axis_tready is high; characters that raise two tokens (a run closed by
// a single-character token) set the sustained limit. s_axis_tready drops only when the
// queue could not take the worst case from the character in flight plus a new one.
// Reset clears the lexer state and the queue.
module arithmetic_expression_lexer_unit import alx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // character[7:0]
	input  logic        s_axis_tuser,  // end_of_input
	// output tokens
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // token_kind[3:0], start_column[19:4],
	                                   // token_length[35:20], zero[39:36]
	output logic        m_axis_tlast   // last_of_run
);

	logic             in_valid_s1;
	in_item_t         in_item_s1;
	tok_pair_t        toks;
	tok_t             head;
	logic [LVL_W-1:0] level;
	logic             s_accept;

	// Room check: queue level plus two slots for the character in the input
	// register must leave two slots for the next one.
	assign s_axis_tready = (level + (in_valid_s1 ? LVL_W'(2) : LVL_W'(0)))
	                       <= LVL_W'(FIFO_DEPTH - 2);
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// input register; it never stalls, the lexer takes it every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else begin
			in_valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			in_item_s1.ch  <= s_axis_tdata;
			in_item_s1.eoi <= s_axis_tuser;
		end
	end

	alx_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid_s1),
		.in_item  (in_item_s1),
		.toks     (toks)
	);

	alx_tok_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (toks),
		.pop        (m_axis_tready),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.level      (level)
	);

	assign m_axis_tdata = {4'b0000, head.len, head.start, head.kind};
	assign m_axis_tlast = head.last;

	// a character taken now always finds its two slots later
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 |-> (level <= LVL_W'(FIFO_DEPTH - 2)))
		else $error("input register holds a character without queue room");

	// a two-token push only happens when the first token is not last of run
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && toks.v1) |-> (!toks.t0.last && toks.t1.last))
		else $error("last_of_run misplaced on a token pair");

	// tokens come only from a character in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		toks.v0 |-> in_valid_s1)
		else $error("token produced without an input transaction");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the arithmetic expression lexer, checked against a local lexer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alx_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_SPACE,
		MODE_MINUS
	} lex_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // character[7:0]
	logic        s_axis_tuser = 1'b0;   // end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;          // token_kind[3:0], start_column[19:4],
	                                    // token_length[35:20], zero[39:36]
	logic        m_axis_tlast;          // last_of_run

	// Lexer model state, advanced once per accepted input transaction.
	lex_mode_t   run_mode = MODE_IDLE;
	logic [15:0] run_start = '0;
	logic [15:0] run_len = '0;
	logic [15:0] column = '0;
	logic        saw_dot = 1'b0;

	tok_t expected_tokens[$];
	int   errors = 0;
	int   items_sent = 0;
	int   stall_left = 0;
	bit   calm = 1'b0;  // no gaps and no new stalls start while set

	arithmetic_expression_lexer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v >= 16'(CNT_LIMIT)) ? 16'(CNT_LIMIT) : v + 16'd1;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic tok_t make_token(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.last  = 1'b0;
		return t;
	endfunction

	// Token for the open run; only called when a run is open.
	function automatic tok_t pending_token();
		case (run_mode)
		MODE_NUM:   return make_token(saw_dot ? K_FLOAT : K_INT, run_start, run_len);
		MODE_IDENT: return make_token(K_IDENT, run_start, run_len);
		MODE_SPACE: return make_token(K_SPACE, run_start, run_len);
		default:    return make_token(K_MINUS, run_start, 16'd1);
		endcase
	endfunction

	function automatic logic [3:0] single_kind(logic [7:0] c);
		case (c)
		"(":     return K_OPEN;
		")":     return K_CLOSE;
		"+":     return K_PLUS;
		"*":     return K_MUL;
		"/":     return K_DIV;
		";":     return K_SEMI;
		default: return K_UNKNOWN;
		endcase
	endfunction

	// Advance the model by one input transaction and queue the tokens it raises.
	function automatic void lex_step(logic [7:0] c, logic eoi);
		tok_t        toks[$];
		logic [15:0] at;
		logic        grows;
		at = column;
		if (eoi) begin
			if (run_mode != MODE_IDLE)
				toks = {toks, pending_token()};
			run_mode  = MODE_IDLE;
			saw_dot   = 1'b0;
			run_start = '0;
			column    = '0;
		end else begin
			column = sat_inc(column);
			case (run_mode)
			MODE_NUM:   grows = is_digit(c) || c == ".";
			MODE_IDENT: grows = is_alpha(c) || c == "_";
			MODE_SPACE: grows = c == " ";
			default:    grows = 1'b0;
			endcase
			if (run_mode == MODE_MINUS && c == ">") begin
				toks = {toks, make_token(K_ARROW, run_start, 16'd2)};
				run_mode = MODE_IDLE;
			end else if (grows) begin
				run_len = sat_inc(run_len);
				if (c == ".")
					saw_dot = 1'b1;
			end else begin
				// the byte closes whatever run is open, then starts its own token
				if (run_mode != MODE_IDLE)
					toks = {toks, pending_token()};
				run_mode = MODE_IDLE;
				saw_dot  = 1'b0;
				if (is_digit(c))
					run_mode = MODE_NUM;
				else if (is_alpha(c))
					run_mode = MODE_IDENT;
				else if (c == " ")
					run_mode = MODE_SPACE;
				else if (c == "-")
					run_mode = MODE_MINUS;
				else
					toks = {toks, make_token(single_kind(c), at, 16'd1)};
				if (run_mode != MODE_IDLE) begin
					run_start = at;
					run_len   = 16'd1;
				end
			end
		end
		if (toks.size() > 0)
			toks[toks.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, toks};
	endfunction

	function automatic void check_token(logic [39:0] data, logic tlast);
		tok_t want;
		if (expected_tokens.size() == 0) begin
			$error("token with nothing expected: tdata=%h tlast=%b", data, tlast);
			errors++;
			return;
		end
		want = expected_tokens.pop_front();
		if (data[3:0] != want.kind) begin
			$error("token_kind: expected %0d, got %0d", want.kind, data[3:0]);
			errors++;
		end
		if (data[19:4] != want.start) begin
			$error("start_column: expected %0d, got %0d", want.start, data[19:4]);
			errors++;
		end
		if (data[35:20] != want.len) begin
			$error("token_length: expected %0d, got %0d", want.len, data[35:20]);
			errors++;
		end
		if (tlast != want.last) begin
			$error("last_of_run: expected %0d, got %0d", want.last, tlast);
			errors++;
		end
	endfunction

	// Both handshakes are sampled at the edge; tokens are checked before the
	// model advances, since a character never yields a token in its own cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_token(m_axis_tdata, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				lex_step(s_axis_tdata, s_axis_tuser);
		end
	end

	// ---------------------------------------------------------------- traffic

	// Mostly short pauses, now and then a long one.
	function automatic int pick_pause();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= pick_pause() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// tvalid stays high between back-to-back transactions; it only drops for a gap.
	task automatic send_item(input logic [7:0] ch, input logic eoi);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= eoi;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
	endfunction

	// Bytes that sit on class boundaries or change the lexer's decisions.
	function automatic logic [7:0] rand_tricky();
		case ($urandom_range(0, 7))
		0:       return " ";
		1:       return "-";
		2:       return ">";
		3:       return ".";
		4:       return "_";
		5:       return rand_digit();
		6:       return rand_letter();
		default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	// One well-formed lexeme with random content, or a stray byte no token starts with.
	task automatic send_lexeme(input int sel);
		case (sel)
		0: begin
			send_item(rand_digit(), 1'b0);
			repeat ($urandom_range(0, 5))
				send_item(($urandom_range(0, 3) == 0) ? 8'(".") : rand_digit(), 1'b0);
		end
		1: begin
			send_item(rand_letter(), 1'b0);
			repeat ($urandom_range(0, 5))
				send_item(($urandom_range(0, 3) == 0) ? 8'("_") : rand_letter(), 1'b0);
		end
		2: repeat ($urandom_range(1, 4)) send_item(" ", 1'b0);
		3: begin
			send_item("-", 1'b0);
			send_item(">", 1'b0);
		end
		4: send_item("-", 1'b0);
		5: send_item("(", 1'b0);
		6: send_item(")", 1'b0);
		7: send_item("+", 1'b0);
		8: send_item("*", 1'b0);
		9: send_item("/", 1'b0);
		10: send_item(";", 1'b0);
		default: begin
			// a byte no token starts with: stray '>', '.', '_', punctuation or non-ASCII
			case ($urandom_range(0, 4))
			0:       send_item(">", 1'b0);
			1:       send_item(".", 1'b0);
			2:       send_item("_", 1'b0);
			3:       send_item("#", 1'b0);
			default: send_item(8'($urandom_range(128, 255)), 1'b0);
			endcase
		end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// Every token kind, arrow versus lone minus, byte extremes, end marker
	// flushing a minus and end marker with nothing open.
	task automatic test_directed();
		string text;
		int    i;
		text = "12 x_y-> 3.4-+(a)*/;";
		for (i = 0; i < text.len(); i++)
			send_item(text[i], 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item("-", 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
	endtask

	// Random expressions built from lexemes and stray bytes, some closed by an end marker.
	task automatic test_expressions(input int goal);
		int stop_at;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 8))
				send_lexeme($urandom_range(0, 11));
			if ($urandom_range(0, 2) == 0)
				send_item(8'($urandom), 1'b1);
		end
		calm = 1'b0;
	endtask

	// Arbitrary bytes, biased toward class boundaries, with stray end markers.
	task automatic test_noise(input int goal);
		int stop_at;
		stop_at = items_sent + goal;
		while (items_sent < stop_at)
			send_item(($urandom_range(0, 2) == 0) ? rand_tricky() : 8'($urandom),
			          $urandom_range(0, 11) == 0);
		send_item(8'($urandom), 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_expressions(340);
		test_noise(90);
		s_axis_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
